// ===== rtl/sse_pkg.sv =====
package sse_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ModeW       = 3;
  localparam int unsigned DataW       = 32;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [ModeW-1:0] {
    ModeAppend  = 3'd0,
    ModeGet     = 3'd1,
    ModeShow    = 3'd2,
    ModeReverse = 3'd3,
    ModeCut     = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusRange = 2'd2
  } status_e;

endpackage

// ===== rtl/sse_if.sv =====
interface sse_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [sse_pkg::ModeW-1:0]      mode;
  logic signed [sse_pkg::DataW-1:0]      operand_a;
  logic signed [sse_pkg::DataW-1:0]      operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

interface sse_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sse_pkg::DataW-1:0]      element_value;
  logic                                  element_present;
  logic                                  last_of_run;
  logic        [sse_pkg::StatusW-1:0]    status;

  modport source (output valid, output element_value, output element_present,
                  output last_of_run, output status, input ready);
  modport sink   (input valid, input element_value, input element_present,
                  input last_of_run, input status, output ready);
endinterface

// ===== rtl/sse_store.sv =====
module sse_store #(
  parameter int unsigned CAPACITY = sse_pkg::DefCapacity,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [sse_pkg::DataW-1:0]     wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [sse_pkg::DataW-1:0]     rdata_o
);

  logic [sse_pkg::DataW-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/sequence_store_engine_unit.sv =====
// Ordered list of signed 32-bit values held in a ring store of CAPACITY
// entries, with a start position, an element count and a reversed-order flag.
// Append, reverse, cut, undefined modes, a show of an empty list and every
// rejected request give their single result word in the cycle after the
// input word is taken. A get passes through a read state, since the element
// comes out of the synchronous store port. A show first reads the first
// element from the store, then gives one element word per cycle while the
// output is not stalled, and no input word is taken until the last one is out.
// The store needs no clearing after reset, and output stalls hold each step.
module sequence_store_engine_unit #(
  parameter int unsigned CAPACITY = sse_pkg::DefCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sse_in_if.sink    in_i,
  sse_out_if.source out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StGet  = 2'd1;
  localparam logic [1:0] StShow = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [AW-1:0]                 start_q, start_d;
  logic [CW-1:0]                 count_q, count_d;
  logic                          rev_q, rev_d;
  logic [AW-1:0]                 idx_q, idx_d;

  logic                          out_valid_q, out_valid_d;
  logic [sse_pkg::DataW-1:0]     out_value_q, out_value_d;
  logic                          out_present_q, out_present_d;
  logic                          out_last_q, out_last_d;
  logic [sse_pkg::StatusW-1:0]   out_status_q, out_status_d;

  logic                          slot_free;
  logic                          accept;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic [sse_pkg::DataW-1:0]     rdata;

  logic                          a_ok;
  logic                          b_gt_a;
  logic                          b_ok;
  logic [sse_pkg::DataW-1:0]     span;
  logic [CW-1:0]                 keep;
  logic [AW-1:0]                 cut_x;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] cnt,
                                         input logic          rev,
                                         input logic [AW-1:0] i);
    logic [CW-1:0] back;
    back = cnt - CW'(1) - CW'(i);
    return rev ? wrap(base, back[AW-1:0]) : wrap(base, i);
  endfunction

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && slot_free;
  assign accept = in_i.valid && in_i.ready;

  assign a_ok   = !in_i.operand_a[sse_pkg::DataW-1] &&
                  ($unsigned(in_i.operand_a) < sse_pkg::DataW'(count_q));
  assign b_gt_a = in_i.operand_b > in_i.operand_a;
  assign b_ok   = !b_gt_a || ($unsigned(in_i.operand_b) < sse_pkg::DataW'(count_q));
  assign span   = in_i.operand_b - in_i.operand_a + sse_pkg::DataW'(1);
  assign keep   = b_gt_a ? span[CW-1:0] : CW'(1);
  assign cut_x  = in_i.operand_a[AW-1:0];

  always_comb begin
    state_d       = state_q;
    start_d       = start_q;
    count_d       = count_q;
    rev_d         = rev_q;
    idx_d         = idx_q;
    we            = 1'b0;
    waddr         = wrap(start_q, count_q[AW-1:0]);
    out_valid_d   = out_valid_q && !out_o.ready;
    out_value_d   = out_value_q;
    out_present_d = out_present_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          out_valid_d   = 1'b1;
          out_value_d   = '0;
          out_present_d = 1'b0;
          out_last_d    = 1'b1;
          out_status_d  = sse_pkg::StatusOk;
          case (sse_pkg::mode_e'(in_i.mode))
            sse_pkg::ModeAppend: begin
              if (count_q == CW'(CAPACITY)) begin
                out_status_d = sse_pkg::StatusFull;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
                if (rev_q) begin
                  start_d = (start_q == '0) ? AW'(CAPACITY - 1) : start_q - AW'(1);
                  waddr   = start_d;
                end
              end
            end
            sse_pkg::ModeGet: begin
              if (!a_ok) begin
                out_status_d = sse_pkg::StatusRange;
              end else begin
                out_valid_d = 1'b0;
                idx_d       = in_i.operand_a[AW-1:0];
                state_d     = StGet;
              end
            end
            sse_pkg::ModeShow: begin
              if (count_q != '0) begin
                out_valid_d = 1'b0;
                idx_d       = '0;
                state_d     = StShow;
              end
            end
            sse_pkg::ModeReverse: begin
              rev_d = !rev_q;
            end
            sse_pkg::ModeCut: begin
              if (!a_ok || !b_ok) begin
                out_status_d = sse_pkg::StatusRange;
              end else begin
                count_d = keep;
                if (rev_q) begin
                  start_d = wrap(start_q, AW'(count_q - CW'(cut_x) - keep));
                end else begin
                  start_d = wrap(start_q, cut_x);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      StGet: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_value_d   = rdata;
          out_present_d = 1'b1;
          out_last_d    = 1'b1;
          out_status_d  = sse_pkg::StatusOk;
          state_d       = StIdle;
        end
      end
      StShow: begin
        if (slot_free) begin
          out_valid_d   = 1'b1;
          out_value_d   = rdata;
          out_present_d = 1'b1;
          out_status_d  = sse_pkg::StatusOk;
          out_last_d    = (CW'(idx_q) == count_q - CW'(1));
          if (out_last_d) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign raddr = phys(start_q, count_q, rev_q, idx_d);

  sse_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.operand_a),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q   <= out_value_d;
    out_present_q <= out_present_d;
    out_last_q    <= out_last_d;
    out_status_q  <= out_status_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.element_value   = out_value_q;
  assign out_o.element_present = out_present_q;
  assign out_o.last_of_run     = out_last_q;
  assign out_o.status          = out_status_q;

endmodule

// ===== rtl/sse_checker.sv =====
module sse_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [sse_pkg::DataW-1:0]  out_value_i,
  input logic                              out_present_i,
  input logic                              out_last_i,
  input logic [sse_pkg::StatusW-1:0]       out_status_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
      $stable(out_present_i) && $stable(out_last_i) && $stable(out_status_i))
    else $error("Stalled result word changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_present_i |-> out_status_i == sse_pkg::StatusOk)
    else $error("Element word carries an error status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_present_i |-> out_value_i == '0 && out_last_i)
    else $error("Word without element is not a zero final word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("Input taken in the middle of a show run.");

endmodule

bind sequence_store_engine_unit sse_checker u_sse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_value_i   (out_o.element_value),
  .out_present_i (out_o.element_present),
  .out_last_i    (out_o.last_of_run),
  .out_status_i  (out_o.status)
);
